FILE: sv/err_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// err_pkg
// Shared constants and tables for the ellipse radial residual unit.
// ----------------------------------------------------------------------------
package err_pkg;

   localparam int CordicStages = 16;
   localparam int AtanEntries  = 30;
   localparam int CordicGainQ30 = 32'h26DD3B6A;

   localparam logic [2:0] CSR_CENTER_X = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y = 3'd1;
   localparam logic [2:0] CSR_RADIUS_A = 3'd2;
   localparam logic [2:0] CSR_RADIUS_B = 3'd3;
   localparam logic [2:0] CSR_ROTATION = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_CENTER = 2'd1;
   localparam logic [1:0] STATUS_ZERO_R = 2'd2;

   // arctan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_lookup(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
         3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
         24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/err_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// err_stream_if
// Valid/ready channels for points and residuals.
// ----------------------------------------------------------------------------
interface err_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface err_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] resid_x;
   logic signed [31:0] resid_y;
   logic [1:0]         status;
   modport source (output valid, output resid_x, output resid_y, output status,
                   input ready);
   modport sink   (input valid, input resid_x, input resid_y, input status,
                   output ready);
endinterface
`default_nettype wire

FILE: sv/ellipse_radial_residual_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_radial_residual_unit
// Radial residual of a point to a rotated ellipse, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one query point (point_x, point_y) per item; rsp_ returns
//   one residual (resid_x, resid_y, status) per item, in order.
//   csr_ writes center, radii and rotation; write only while the pipe is idle.
//   Throughput: one item per cycle unless rsp_ stalls. The pipeline has LAT = 138
//   stages: offset, 16 vectoring CORDIC stages, angle fold, 16 rotation
//   CORDIC stages for cos/sin of u and of t, magnitude, products, normalize,
//   squares, 32-step square root, divider operands, 64-step restoring
//   divider, radius clamp, final multiply and saturate.
//   Every stage advances together under one enable: when rsp_ stalls and
//   the last stage is full the whole pipe holds, bubbles included.
//   Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module ellipse_radial_residual_unit
   import err_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   err_req_if.sink     req_ch,
   err_rsp_if.source   rsp_ch,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam int NS  = CordicStages;
   localparam int SQ  = 32;   // square root steps
   localparam int DV  = 64;   // divider steps
   // stage plan
   localparam int P_VEC  = 1;             // after offset
   localparam int P_ROT  = P_VEC + NS;    // after vectoring
   localparam int P_CS   = P_ROT + 1 + NS;// after rotation cordic
   localparam int P_AB   = P_CS + 1;      // A,B products
   localparam int P_NRM  = P_AB + 1;      // normalize shift
   localparam int P_SQ0  = P_NRM + 1;     // sum of squares
   localparam int P_SQE  = P_SQ0 + SQ;
   localparam int P_DV0  = P_SQE + 1;
   localparam int P_DVE  = P_DV0 + DV;
   localparam int P_R    = P_DVE + 1;
   localparam int P_MUL  = P_R + 1;
   localparam int LAT    = P_MUL + 2;     // multiply, then saturate

   // configuration registers
   logic signed [31:0] center_x_ff, center_y_ff;
   logic [31:0]        radius_a_ff, radius_b_ff;
   logic [15:0]        rotation_ff;

   // load a register on a write
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_a_ff <= 32'd65536;
         radius_b_ff <= 32'd65536;
         rotation_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_RADIUS_A: radius_a_ff <= csr_wdata;
            CSR_RADIUS_B: radius_b_ff <= csr_wdata;
            CSR_ROTATION: rotation_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // pipeline enable: advance unless the output holds an untaken item
   logic [LAT-1:0] vld_ff;
   logic           adv;
   assign adv = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
   end

   // per item carried data
   logic signed [32:0] dx_ff [LAT];
   logic signed [32:0] dy_ff [LAT];
   logic [1:0]         st_ff [LAT];
   logic               rz_ff [LAT];   // one radius zero: r = 0

   // vectoring cordic datapath
   logic signed [35:0] vx_ff [NS+1];
   logic signed [35:0] vy_ff [NS+1];
   logic [31:0]        vz_ff [NS+1];

   // rotation cordic: two lanes, u and t
   logic signed [33:0] ux_ff [NS+1], uy_ff [NS+1], uz_ff [NS+1];
   logic signed [33:0] tx_ff [NS+1], ty_ff [NS+1], tz_ff [NS+1];
   logic [NS:0]        tneg_ff;

   // stage 0: offset and special cases
   logic signed [32:0] dx0, dy0;
   logic [1:0]         st0;
   always_comb begin
      dx0 = 33'(req_ch.point_x) - 33'(center_x_ff);
      dy0 = 33'(req_ch.point_y) - 33'(center_y_ff);
      if (radius_a_ff == 0 && radius_b_ff == 0) st0 = STATUS_ZERO_R;
      else if (dx0 == 0 && dy0 == 0)           st0 = STATUS_CENTER;
      else                                     st0 = STATUS_OK;
   end

   // carry item fields along the pipe
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff[0] <= dx0;
         dy_ff[0] <= dy0;
         st_ff[0] <= st0;
         rz_ff[0] <= (radius_a_ff == 0) || (radius_b_ff == 0);
         for (int k = 1; k < LAT; k++) begin
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
            st_ff[k] <= st_ff[k-1];
            rz_ff[k] <= rz_ff[k-1];
         end
      end
   end

   // vectoring entry: half turn when dx < 0
   always_ff @(posedge clock) begin
      if (adv) begin
         if (dx0 < 0) begin
            vx_ff[0] <= -36'(dx0);
            vy_ff[0] <= -36'(dy0);
            vz_ff[0] <= 32'h80000000;
         end else begin
            vx_ff[0] <= 36'(dx0);
            vy_ff[0] <= 36'(dy0);
            vz_ff[0] <= '0;
         end
      end
   end

   // vectoring stages, steer on sign of y
   for (genvar i = 0; i < NS; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (adv) begin
            if (vy_ff[i] >= 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + atan_lookup(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - atan_lookup(i);
            end
         end
      end
   end

   // rotation entry: fold angles to the right half plane
   logic [31:0] ang_u, ang_t, au, at;
   logic        nu, nt;
   always_comb begin
      ang_t = vz_ff[NS];
      ang_u = vz_ff[NS] + {rotation_ff, 16'h0};
      nu = ang_u[31] ^ ang_u[30];
      nt = ang_t[31] ^ ang_t[30];
      au = nu ? ang_u - 32'h80000000 : ang_u;
      at = nt ? ang_t - 32'h80000000 : ang_t;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ux_ff[0] <= 34'(CordicGainQ30);
         uy_ff[0] <= '0;
         uz_ff[0] <= 34'($signed(au));
         tx_ff[0] <= 34'(CordicGainQ30);
         ty_ff[0] <= '0;
         tz_ff[0] <= 34'($signed(at));
         tneg_ff[0] <= nt;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            tneg_ff[i+1] <= tneg_ff[i];
            if (uz_ff[i] >= 0) begin
               ux_ff[i+1] <= ux_ff[i] - (uy_ff[i] >>> i);
               uy_ff[i+1] <= uy_ff[i] + (ux_ff[i] >>> i);
               uz_ff[i+1] <= uz_ff[i] - 34'(atan_lookup(i));
            end else begin
               ux_ff[i+1] <= ux_ff[i] + (uy_ff[i] >>> i);
               uy_ff[i+1] <= uy_ff[i] - (ux_ff[i] >>> i);
               uz_ff[i+1] <= uz_ff[i] + 34'(atan_lookup(i));
            end
            if (tz_ff[i] >= 0) begin
               tx_ff[i+1] <= tx_ff[i] - (ty_ff[i] >>> i);
               ty_ff[i+1] <= ty_ff[i] + (tx_ff[i] >>> i);
               tz_ff[i+1] <= tz_ff[i] - 34'(atan_lookup(i));
            end else begin
               tx_ff[i+1] <= tx_ff[i] + (ty_ff[i] >>> i);
               ty_ff[i+1] <= ty_ff[i] - (tx_ff[i] >>> i);
               tz_ff[i+1] <= tz_ff[i] + 34'(atan_lookup(i));
            end
         end
      end
   end

   // cos/sin results: |cos u|, |sin u| and signed cos t, sin t
   logic [32:0]        cu_ff, su_ff;
   logic signed [33:0] ct_ff [P_MUL-P_CS+1];
   logic signed [33:0] stn_ff [P_MUL-P_CS+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         cu_ff <= ux_ff[NS] < 0 ? 33'(-ux_ff[NS]) : 33'(ux_ff[NS]);
         su_ff <= uy_ff[NS] < 0 ? 33'(-uy_ff[NS]) : 33'(uy_ff[NS]);
         ct_ff[0]  <= tneg_ff[NS] ? -tx_ff[NS] : tx_ff[NS];
         stn_ff[0] <= tneg_ff[NS] ? -ty_ff[NS] : ty_ff[NS];
         for (int k = 1; k <= P_MUL - P_CS; k++) begin
            ct_ff[k]  <= ct_ff[k-1];
            stn_ff[k] <= stn_ff[k-1];
         end
      end
   end

   // A and B products
   logic [63:0] pa_full, pb_full;
   logic [33:0] a_ff, b_ff;
   assign pa_full = 64'(radius_a_ff) * 64'(cu_ff);
   assign pb_full = 64'(radius_b_ff) * 64'(su_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= 34'(pa_full >> 30);
         b_ff <= 34'(pb_full >> 30);
      end
   end

   // normalize both below 2^31
   logic [30:0] an_ff, bn_ff;
   logic [1:0]  sh_ff [P_DV0-P_NRM+1];
   logic [1:0]  shn;
   always_comb begin
      if (a_ff[33] || b_ff[33])      shn = 2'd3;
      else if (a_ff[32] || b_ff[32]) shn = 2'd2;
      else if (a_ff[31] || b_ff[31]) shn = 2'd1;
      else                           shn = 2'd0;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         an_ff <= 31'(a_ff >> shn);
         bn_ff <= 31'(b_ff >> shn);
         sh_ff[0] <= shn;
         for (int k = 1; k <= P_DV0 - P_NRM; k++) sh_ff[k] <= sh_ff[k-1];
      end
   end

   // sum of squares (two 31x31 products, registered)
   logic [61:0] aa_ff, bb_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         aa_ff <= 62'(an_ff) * 62'(an_ff);
         bb_ff <= 62'(bn_ff) * 62'(bn_ff);
      end
   end

   // square root, one result bit per stage
   logic [62:0] sr_ff [SQ+1];
   logic [31:0] sq_ff [SQ+1];
   always_comb sr_ff[0] = 63'(aa_ff) + 63'(bb_ff);
   always_comb sq_ff[0] = '0;
   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      localparam int BP = 2 * (SQ - 1 - i);
      logic [63:0] trial;
      assign trial = (64'(sq_ff[i]) << (SQ - i)) + (64'd1 << BP);
      always_ff @(posedge clock) begin
         if (adv) begin
            if (64'(sr_ff[i]) >= trial) begin
               sr_ff[i+1] <= 63'(64'(sr_ff[i]) - trial);
               sq_ff[i+1] <= sq_ff[i] | (32'd1 << (SQ - 1 - i));
            end else begin
               sr_ff[i+1] <= sr_ff[i];
               sq_ff[i+1] <= sq_ff[i];
            end
         end
      end
   end

   // divider operands: N = a*b, Dv = D << sh
   logic [63:0] num_ff;
   logic [34:0] den_ff;
   logic        dz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= 64'(radius_a_ff) * 64'(radius_b_ff);
         den_ff <= 35'(sq_ff[SQ]) << sh_ff[P_SQE - P_NRM];
         dz_ff  <= sq_ff[SQ] == 0;
      end
   end

   // restoring divider, one quotient bit per stage
   logic [34:0] rm_ff [DV+1];
   logic [63:0] nq_ff [DV+1];
   logic [34:0] dd_ff [DV+1];
   logic        dzp_ff [DV+1];
   always_comb begin
      rm_ff[0]  = '0;
      nq_ff[0]  = num_ff;
      dd_ff[0]  = den_ff;
      dzp_ff[0] = dz_ff;
   end
   for (genvar i = 0; i < DV; i++) begin : g_div
      logic [35:0] part;
      assign part = {rm_ff[i], nq_ff[i][63]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dd_ff[i+1]  <= dd_ff[i];
            dzp_ff[i+1] <= dzp_ff[i];
            if (part >= 36'(dd_ff[i])) begin
               rm_ff[i+1] <= 35'(part - 36'(dd_ff[i]));
               nq_ff[i+1] <= {nq_ff[i][62:0], 1'b1};
            end else begin
               rm_ff[i+1] <= 35'(part);
               nq_ff[i+1] <= {nq_ff[i][62:0], 1'b0};
            end
         end
      end
   end

   // radius: clamp to the larger radius, zero if one radius is zero
   logic [31:0] big, r_ff;
   assign big = radius_a_ff > radius_b_ff ? radius_a_ff : radius_b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (rz_ff[P_DVE])                              r_ff <= '0;
         else if (dzp_ff[DV] || nq_ff[DV] > 64'(big))   r_ff <= big;
         else                                           r_ff <= nq_ff[DV][31:0];
      end
   end

   // r * (cos t, sin t)
   logic signed [66:0] mx_ff, my_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= $signed({35'b0, r_ff}) * 67'(ct_ff[P_R - P_CS]);
         my_ff <= $signed({35'b0, r_ff}) * 67'(stn_ff[P_R - P_CS]);
      end
   end

   // subtract and saturate
   logic signed [37:0] ex, ey;
   logic signed [31:0] ox_ff, oy_ff;
   logic [1:0]         os_ff;
   assign ex = 38'(dx_ff[P_MUL]) - 38'(mx_ff >>> 30);
   assign ey = 38'(dy_ff[P_MUL]) - 38'(my_ff >>> 30);
   function automatic logic signed [31:0] sat(input logic signed [37:0] v);
      if (v > 38'sd2147483647)       return 32'h7FFFFFFF;
      else if (v < -38'sd2147483648) return 32'h80000000;
      else                           return v[31:0];
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         os_ff <= st_ff[P_MUL];
         if (st_ff[P_MUL] != STATUS_OK) begin
            ox_ff <= '0;
            oy_ff <= '0;
         end else begin
            ox_ff <= sat(ex);
            oy_ff <= sat(ey);
         end
      end
   end

   assign rsp_ch.valid   = vld_ff[LAT-1];
   assign rsp_ch.resid_x = ox_ff;
   assign rsp_ch.resid_y = oy_ff;
   assign rsp_ch.status  = os_ff;

endmodule
`default_nettype wire

FILE: dv/err_residual_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// err_residual_checker
// Watches the point and residual channels of the ellipse radial residual
// unit, predicts each residual from the accepted point and the current
// register settings, and compares the residuals in order.
// ----------------------------------------------------------------------------
module err_residual_checker
   import err_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   err_req_if          req_ch,
   err_rsp_if          rsp_ch,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic signed [31:0] resid_x;
      logic signed [31:0] resid_y;
      logic [1:0]         status;
   } residual_type;

   residual_type       residual_q[$];
   logic signed [63:0] cfg_cx, cfg_cy;
   logic [63:0]        cfg_ra, cfg_rb;
   logic [15:0]        cfg_rot;

   assign pending_count = residual_q.size();

   function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
      return v >>> s;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   // vectoring CORDIC: angle of (x, y) as a 32-bit binary angle
   function automatic logic [31:0] angle_of(logic signed [63:0] x, logic signed [63:0] y);
      logic [31:0]        z;
      logic signed [63:0] xs, ys;
      z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < CordicStages; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_lookup(i);
         end else begin
            x -= ys; y += xs; z -= atan_lookup(i);
         end
      end
      return z;
   endfunction

   // rotation CORDIC: cos and sin in Q2.30
   function automatic void unit_vector(input logic [31:0] ang,
                                       output logic signed [63:0] c,
                                       output logic signed [63:0] s);
      logic signed [63:0] x, y, z, xs, ys;
      logic               neg;
      x = 64'(CordicGainQ30);
      y = 0;
      neg = ((ang + 32'h40000000) & 32'h80000000) != 0;
      if (neg) ang = ang - 32'h80000000;
      z = $signed({{32{ang[31]}}, ang});
      for (int i = 0; i < CordicStages; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= $signed({32'd0, atan_lookup(i)});
         end else begin
            x += ys; y -= xs; z += $signed({32'd0, atan_lookup(i)});
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic logic [63:0] ellipse_radius(logic [31:0] u);
      logic signed [63:0] c, s;
      logic [63:0]        a_term, b_term, root, big, q;
      int                 sh;
      big = (cfg_ra > cfg_rb) ? cfg_ra : cfg_rb;
      if (cfg_ra == 0 || cfg_rb == 0) return 0;
      unit_vector(u, c, s);
      a_term = (cfg_ra * (c < 0 ? -c : c)) >> 30;
      b_term = (cfg_rb * (s < 0 ? -s : s)) >> 30;
      sh = 0;
      while (a_term >= 64'h80000000 || b_term >= 64'h80000000) begin
         a_term >>= 1; b_term >>= 1; sh++;
      end
      root = root_floor(a_term * a_term + b_term * b_term);
      if (root == 0) return big;
      q = (cfg_ra * cfg_rb) / (root << sh);
      return (q > big) ? big : q;
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic residual_type predict_residual(logic signed [31:0] px,
                                                     logic signed [31:0] py);
      residual_type       res;
      logic signed [63:0] dx, dy, ct, st, r;
      logic [31:0]        t;
      res = '0;
      dx = 64'(px) - cfg_cx;
      dy = 64'(py) - cfg_cy;
      if (cfg_ra == 0 && cfg_rb == 0) begin
         res.status = STATUS_ZERO_R;
         return res;
      end
      if (dx == 0 && dy == 0) begin
         res.status = STATUS_CENTER;
         return res;
      end
      t = angle_of(dx, dy);
      r = ellipse_radius(t + {cfg_rot, 16'd0});
      unit_vector(t, ct, st);
      res.resid_x = clamp32(dx - shr_floor(r * ct, 30));
      res.resid_y = clamp32(dy - shr_floor(r * st, 30));
      res.status = STATUS_OK;
      return res;
   endfunction

   // track registers, predict on input, compare on output
   always @(posedge clock) begin
      residual_type got, want;
      if (reset) begin
         cfg_cx <= 0; cfg_cy <= 0; cfg_ra <= 65536; cfg_rb <= 65536; cfg_rot <= 0;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CENTER_X: cfg_cx <= 64'($signed(csr_wdata));
               CSR_CENTER_Y: cfg_cy <= 64'($signed(csr_wdata));
               CSR_RADIUS_A: cfg_ra <= {32'd0, csr_wdata};
               CSR_RADIUS_B: cfg_rb <= {32'd0, csr_wdata};
               CSR_ROTATION: cfg_rot <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            residual_q.push_back(predict_residual(req_ch.point_x, req_ch.point_y));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.resid_x = rsp_ch.resid_x;
            got.resid_y = rsp_ch.resid_y;
            got.status = rsp_ch.status;
            if (residual_q.size() == 0) begin
               $error("residual with no point outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = residual_q.pop_front();
               if (got.resid_x !== want.resid_x)
                  $error("resid_x expected %0d actual %0d", want.resid_x, got.resid_x);
               if (got.resid_y !== want.resid_y)
                  $error("resid_y expected %0d actual %0d", want.resid_y, got.resid_y);
               if (got.status !== want.status)
                  $error("status expected %0d actual %0d", want.status, got.status);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

FILE: dv/ellipse_radial_residual_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipse_radial_residual_unit_tb
// Drives points through the residual unit over several register settings,
// with random gaps and stalls and one long output stall; the checker
// predicts and compares every residual.
// ----------------------------------------------------------------------------
module ellipse_radial_residual_unit_tb;
   import err_pkg::*;

   localparam int DrainCycles = 400;
   localparam int StallLimit  = 5000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count, pending_count;
   int          idle_cycles = 0;
   int          rsp_wait = 0;
   bit          hold_off = 0;

   err_req_if req_ch();
   err_rsp_if rsp_ch();

   initial begin
      req_ch.valid = 0; req_ch.point_x = 0; req_ch.point_y = 0;
      rsp_ch.ready = 0;
   end

   ellipse_radial_residual_unit u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   err_residual_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // send one point, after a random gap; valid stays high for the next item
   task automatic send_point(logic [31:0] px, logic [31:0] py, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.point_x <= px;
      req_ch.point_y <= py;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // random coordinate: full range one time in four, else within 2^23 of zero
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
         2: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
   endfunction

   function automatic logic [31:0] pick_radius();
      case ($urandom_range(0, 4))
         0: return 32'($urandom_range(1, 16));
         1: return $urandom();
         default: return 32'($urandom_range(32'h00004000, 32'h00080000));
      endcase
   endfunction

   // receiver: after each taken item, hold ready low for a random wait, plus one long hold-off
   always @(posedge clock) begin
      int n;
      if (reset || hold_off) begin
         rsp_ch.ready <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         n = $urandom_range(0, 8);
         rsp_wait <= n;
         rsp_ch.ready <= (n == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ch.ready <= (rsp_wait == 1);
      end else begin
         rsp_ch.ready <= 1;
      end
   end

   // watchdog on acceptance
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || hold_off
          || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("ellipse_radial_residual_unit regression: fail");
         $finish;
      end
   end

   initial begin
      logic [31:0] edge_vals[6];
      edge_vals = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h00010000,
                    32'hFFFF0000};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, field extremes, center point
      send_point(0, 0);
      foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[(i + 2) % 6]);
      send_point(32'h00010000, 0);
      send_point(0, 32'hFFFF0000);
      wait_drained();

      // one radius zero, then both zero (priority over center)
      write_reg(CSR_RADIUS_A, 0);
      send_point(32'h00020000, 32'h00030000);
      send_point(0, 0);
      wait_drained();
      write_reg(CSR_RADIUS_B, 0);
      send_point(0, 0);
      send_point(32'h7FFFFFFF, 32'h80000000);
      wait_drained();

      // extreme radii, rotation and center; saturating offsets
      write_reg(CSR_RADIUS_A, 32'hFFFFFFFF);
      write_reg(CSR_RADIUS_B, 32'h00000001);
      write_reg(CSR_ROTATION, 32'h0000FFFF);
      write_reg(CSR_CENTER_X, 32'h80000000);
      write_reg(CSR_CENTER_Y, 32'h7FFFFFFF);
      send_point(32'h80000000, 32'h7FFFFFFF);
      send_point(32'h7FFFFFFF, 32'h80000000);
      send_point(0, 0);
      send_point(32'hFFFFFFFF, 32'hFFFFFFFF);
      wait_drained();
      write_reg(CSR_RADIUS_B, 32'hFFFFFFFF);
      write_reg(CSR_ROTATION, 32'h00008000);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
      send_point(0, 32'h80000000);
      wait_drained();

      // random phases, each with fresh settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_CENTER_X, (ph % 3 == 0) ? $urandom() : pick_coord());
         write_reg(CSR_CENTER_Y, (ph % 3 == 0) ? $urandom() : pick_coord());
         write_reg(CSR_RADIUS_A, pick_radius());
         write_reg(CSR_RADIUS_B, pick_radius());
         write_reg(CSR_ROTATION, $urandom_range(0, 16'hFFFF));
         if (ph == 2) fork
            begin
               hold_off <= 1;
               repeat (600) @(posedge clock);
               hold_off <= 0;
            end
         join_none
         for (int n = 0; n < 235; n++) begin
            if (n % 50 == 7) send_point(u_checker.cfg_cx[31:0], u_checker.cfg_cy[31:0]);
            else send_point(pick_coord(), pick_coord(), ph == 2);
         end
         wait_drained();
      end

      if (fail_count == 0 && pending_count == 0)
         $display("ellipse_radial_residual_unit regression: pass");
      else
         $display("ellipse_radial_residual_unit regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
sv/err_pkg.sv
sv/err_stream_if.sv
sv/ellipse_radial_residual_unit.sv
dv/err_residual_checker.sv
dv/ellipse_radial_residual_unit_tb.sv
